FILE: rtl/i2cbts_pkg.sv
// Shared types and constants of the buffered two-wire transfer sequencer.
package i2cbts_pkg;

    localparam int BUF_DEPTH = 128;
    localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    // request kinds
    localparam logic [2:0] REQ_BUS_EVENT  = 3'd0;
    localparam logic [2:0] REQ_LOAD_BYTE  = 3'd1;
    localparam logic [2:0] REQ_START_WR   = 3'd2;
    localparam logic [2:0] REQ_START_RD   = 3'd3;
    localparam logic [2:0] REQ_READ_BYTE  = 3'd4;
    localparam logic [2:0] REQ_TAKE_MSG   = 3'd5;

    // start request results
    localparam logic [1:0] RS_OK       = 2'd0;
    localparam logic [1:0] RS_BUSY     = 2'd1;
    localparam logic [1:0] RS_TOO_LONG = 2'd2;

    // bus status codes, low three bits cleared
    localparam logic [7:0] ST_BUS_ERROR    = 8'h00;
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_REP_START    = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK    = 8'h18;
    localparam logic [7:0] ST_SLA_W_NACK   = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK   = 8'h28;
    localparam logic [7:0] ST_DATA_W_NACK  = 8'h30;
    localparam logic [7:0] ST_SLA_R_ACK    = 8'h40;
    localparam logic [7:0] ST_SLA_R_NACK   = 8'h48;
    localparam logic [7:0] ST_DATA_R_ACK   = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK  = 8'h58;
    localparam logic [7:0] ST_SR_OWN_ADDR  = 8'h60;
    localparam logic [7:0] ST_SR_DATA_ACK  = 8'h80;
    localparam logic [7:0] ST_SR_DATA_NACK = 8'h88;
    localparam logic [7:0] ST_SR_GEN_ACK   = 8'h90;
    localparam logic [7:0] ST_SR_GEN_NACK  = 8'h98;
    localparam logic [7:0] ST_MASK         = 8'hF8;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } mode_t;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

endpackage

FILE: rtl/i2c_buffered_transfer_sequencer_core.sv
// Top level of the buffered two-wire transfer sequencer.
// A result is registered and appears in the cycle after its request transfer.
// Throughput: one request per cycle unless the sink stalls; the buffer is a
// single-port-per-side RAM with registered read; a request either reads or writes it.
// Reset (rst_n low, asynchronous) idles the sequencer, clears the index, length,
// address and message flag, sets the held ack bit; buffer contents stay undefined.
module i2c_buffered_transfer_sequencer_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] status_code, [15:8] rx_byte, [22:16] peer_address, [30:23] length,
    // [37:31] buf_index, [45:38] byte_value, [47:46] zero
    input  logic [i2cbts_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [2:0] req_type
    input  logic [2:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [1:0] req_status, [2] release_bus, [3] send_start, [4] send_stop,
    // [5] ack_enable, [6] tx_valid, [14:7] tx_byte, [15] busy_res,
    // [16] msg_ready, [24:17] msg_length, [32:25] rd_byte, [39:33] zero
    output logic [i2cbts_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam int AW = i2cbts_pkg::BUF_AW;

    // Unpack the request fields.
    logic [2:0] req_type;
    logic [7:0] status_code;
    logic [7:0] rx_byte;
    logic [6:0] peer_address;
    logic [7:0] length;
    logic [6:0] buf_index;
    logic [7:0] byte_value;
    logic [7:0] status_m;

    assign req_type     = s_axis_tuser;
    assign status_code  = s_axis_tdata[7:0];
    assign rx_byte      = s_axis_tdata[15:8];
    assign peer_address = s_axis_tdata[22:16];
    assign length       = s_axis_tdata[30:23];
    assign buf_index    = s_axis_tdata[37:31];
    assign byte_value   = s_axis_tdata[45:38];
    assign status_m     = status_code & i2cbts_pkg::ST_MASK;

    // Sequencer state.
    logic [7:0]        byte_index_reg,  byte_index_next;
    logic [7:0]        xfer_len_reg,    xfer_len_next;
    logic [6:0]        remote_addr_reg, remote_addr_next;
    i2cbts_pkg::mode_t mode_reg,        mode_next;
    logic              msg_flag_reg,    msg_flag_next;
    logic              last_ack_reg,    last_ack_next;
    logic              last_start_reg,  last_start_next;

    // Result stage: everything but the buffer byte, which comes from the RAM register.
    logic              out_valid_reg;
    logic [1:0]        rstat_reg,  rstat_next;
    logic              rel_reg,    rel_next;
    logic              sto_reg,    sto_next;
    logic              txv_reg,    txv_next;
    logic              tx_mem_reg, tx_mem_next;   // tx byte comes from the buffer
    logic [7:0]        tx_addr_reg, tx_addr_next; // address byte when not from buffer
    logic              rd_mem_reg, rd_mem_next;   // rd_byte comes from the buffer
    logic              mem_ok_reg, mem_ok_next;   // buffer read was in range
    logic [7:0]        mlen_reg,   mlen_next;

    // Buffer RAM.
    logic [7:0]        buf_mem [i2cbts_pkg::BUF_DEPTH];
    logic [7:0]        rdata_reg;
    logic              rd_en, wr_en;
    logic [7:0]        rd_idx, wr_idx;
    logic [7:0]        wr_data;

    logic              accept;
    logic [7:0]        bi_inc;

    // A result waiting to be taken blocks the next request only if the sink stalls.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign bi_inc        = byte_index_reg + 8'd1;

    always_comb
    begin
        byte_index_next  = byte_index_reg;
        xfer_len_next    = xfer_len_reg;
        remote_addr_next = remote_addr_reg;
        mode_next        = mode_reg;
        msg_flag_next    = msg_flag_reg;
        last_ack_next    = last_ack_reg;
        last_start_next  = last_start_reg;

        rstat_next   = i2cbts_pkg::RS_OK;
        rel_next     = 1'b0;
        sto_next     = 1'b0;
        txv_next     = 1'b0;
        tx_mem_next  = 1'b0;
        tx_addr_next = 8'd0;
        rd_mem_next  = 1'b0;
        mlen_next    = 8'd0;

        rd_en   = 1'b0;
        rd_idx  = 8'd0;
        wr_en   = 1'b0;
        wr_idx  = byte_index_reg;
        wr_data = rx_byte;

        case (req_type)
            i2cbts_pkg::REQ_BUS_EVENT:
            begin
                case (status_m)
                    i2cbts_pkg::ST_BUS_ERROR:
                    begin
                    end
                    i2cbts_pkg::ST_START, i2cbts_pkg::ST_REP_START:
                    begin
                        txv_next        = 1'b1;
                        tx_addr_next    = {remote_addr_reg, mode_reg == i2cbts_pkg::MODE_READ};
                        rel_next        = 1'b1;
                        last_start_next = 1'b0;
                    end
                    i2cbts_pkg::ST_SLA_W_ACK, i2cbts_pkg::ST_SLA_W_NACK:
                    begin
                        byte_index_next = 8'd1;
                        txv_next        = 1'b1;
                        tx_mem_next     = 1'b1;
                        rd_en           = 1'b1;
                        rd_idx          = 8'd0;
                        rel_next        = 1'b1;
                        last_start_next = 1'b0;
                        last_ack_next   = 1'b1;
                    end
                    i2cbts_pkg::ST_DATA_W_ACK, i2cbts_pkg::ST_DATA_W_NACK:
                    begin
                        rel_next        = 1'b1;
                        last_start_next = 1'b0;
                        last_ack_next   = 1'b1;
                        if (byte_index_reg < xfer_len_reg)
                        begin
                            txv_next        = 1'b1;
                            tx_mem_next     = 1'b1;
                            rd_en           = 1'b1;
                            rd_idx          = byte_index_reg;
                            byte_index_next = bi_inc;
                        end
                        else
                        begin
                            sto_next  = 1'b1;
                            mode_next = i2cbts_pkg::MODE_IDLE;
                        end
                    end
                    i2cbts_pkg::ST_SLA_R_ACK:
                    begin
                        byte_index_next = 8'd0;
                        rel_next        = 1'b1;
                        last_start_next = 1'b0;
                        last_ack_next   = (xfer_len_reg != 8'd1);
                    end
                    i2cbts_pkg::ST_SLA_R_NACK:
                    begin
                        rel_next        = 1'b1;
                        sto_next        = 1'b1;
                        last_start_next = 1'b0;
                        last_ack_next   = 1'b1;
                        mode_next       = i2cbts_pkg::MODE_IDLE;
                    end
                    i2cbts_pkg::ST_DATA_R_ACK, i2cbts_pkg::ST_DATA_R_NACK:
                    begin
                        // store at the old index, then advance
                        wr_en           = 1'b1;
                        byte_index_next = bi_inc;
                        rel_next        = 1'b1;
                        last_start_next = 1'b0;
                        if (xfer_len_reg == bi_inc)
                        begin
                            sto_next      = 1'b1;
                            last_ack_next = 1'b1;
                            msg_flag_next = 1'b1;
                            mode_next     = i2cbts_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            last_ack_next = ({1'b0, bi_inc} + 9'd1 != {1'b0, xfer_len_reg});
                        end
                    end
                    i2cbts_pkg::ST_SR_OWN_ADDR:
                    begin
                        byte_index_next = 8'd0;
                        rel_next        = 1'b1;
                        last_start_next = 1'b0;
                        last_ack_next   = 1'b1;
                    end
                    i2cbts_pkg::ST_SR_DATA_ACK, i2cbts_pkg::ST_SR_DATA_NACK,
                    i2cbts_pkg::ST_SR_GEN_ACK, i2cbts_pkg::ST_SR_GEN_NACK:
                    begin
                        // the first byte of a slave message is its length
                        wr_en           = 1'b1;
                        byte_index_next = bi_inc;
                        if (bi_inc == 8'd1)
                        begin
                            xfer_len_next = rx_byte;
                        end
                        rel_next = 1'b1;
                        if (bi_inc == xfer_len_next)
                        begin
                            last_ack_next = 1'b1;
                            msg_flag_next = 1'b1;
                            mode_next     = i2cbts_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            last_start_next = 1'b0;
                            last_ack_next   = ({1'b0, bi_inc} + 9'd1 != {1'b0, xfer_len_next});
                        end
                    end
                    default:
                    begin
                        rel_next = 1'b1;
                    end
                endcase
            end
            i2cbts_pkg::REQ_LOAD_BYTE:
            begin
                wr_en   = 1'b1;
                wr_idx  = {1'b0, buf_index};
                wr_data = byte_value;
            end
            i2cbts_pkg::REQ_START_WR, i2cbts_pkg::REQ_START_RD:
            begin
                if (mode_reg != i2cbts_pkg::MODE_IDLE)
                begin
                    rstat_next = i2cbts_pkg::RS_BUSY;
                end
                else if ({1'b0, length} > 9'(i2cbts_pkg::BUF_DEPTH))
                begin
                    rstat_next = i2cbts_pkg::RS_TOO_LONG;
                end
                else
                begin
                    remote_addr_next = peer_address;
                    xfer_len_next    = length;
                    mode_next        = (req_type == i2cbts_pkg::REQ_START_WR) ?
                                       i2cbts_pkg::MODE_WRITE : i2cbts_pkg::MODE_READ;
                    rel_next         = 1'b1;
                    last_start_next  = 1'b1;
                    last_ack_next    = 1'b1;
                end
            end
            i2cbts_pkg::REQ_READ_BYTE:
            begin
                rd_mem_next = 1'b1;
                rd_en       = 1'b1;
                rd_idx      = {1'b0, buf_index};
            end
            i2cbts_pkg::REQ_TAKE_MSG:
            begin
                if (msg_flag_reg)
                begin
                    msg_flag_next = 1'b0;
                    mlen_next     = xfer_len_reg;
                end
            end
            default:
            begin
            end
        endcase

        // Drop accesses beyond the buffer; out-of-range reads give zero.
        mem_ok_next = rd_en && ({1'b0, rd_idx} < 9'(i2cbts_pkg::BUF_DEPTH));
        rd_en       = mem_ok_next;
        wr_en       = wr_en && ({1'b0, wr_idx} < 9'(i2cbts_pkg::BUF_DEPTH));
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg  <= 8'd0;
            xfer_len_reg    <= 8'd0;
            remote_addr_reg <= 7'd0;
            mode_reg        <= i2cbts_pkg::MODE_IDLE;
            msg_flag_reg    <= 1'b0;
            last_ack_reg    <= 1'b1;
            last_start_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                byte_index_reg  <= byte_index_next;
                xfer_len_reg    <= xfer_len_next;
                remote_addr_reg <= remote_addr_next;
                mode_reg        <= mode_next;
                msg_flag_reg    <= msg_flag_next;
                last_ack_reg    <= last_ack_next;
                last_start_reg  <= last_start_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; held while the sink stalls since nothing is accepted then.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rstat_reg   <= rstat_next;
            rel_reg     <= rel_next;
            sto_reg     <= sto_next;
            txv_reg     <= txv_next;
            tx_mem_reg  <= tx_mem_next;
            tx_addr_reg <= tx_addr_next;
            rd_mem_reg  <= rd_mem_next;
            mem_ok_reg  <= mem_ok_next;
            mlen_reg    <= mlen_next;
        end
    end

    // Buffer RAM: at most one write or one registered read per transfer. Each request
    // either reads or writes, and a later request sees an earlier write, so no
    // forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            buf_mem[wr_idx[AW-1:0]] <= wr_data;
        end
        if (accept && rd_en)
        begin
            rdata_reg <= buf_mem[rd_idx[AW-1:0]];
        end
    end

    logic [7:0] mem_byte;
    logic [7:0] tx_byte_o;
    logic [7:0] rd_byte_o;
    logic       busy_o;

    assign mem_byte  = mem_ok_reg ? rdata_reg : 8'd0;
    assign tx_byte_o = tx_mem_reg ? mem_byte : tx_addr_reg;
    assign rd_byte_o = rd_mem_reg ? mem_byte : 8'd0;
    assign busy_o    = (mode_reg != i2cbts_pkg::MODE_IDLE);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, rd_byte_o, mlen_reg, msg_flag_reg, busy_o, tx_byte_o,
                            txv_reg, last_ack_reg, sto_reg, last_start_reg, rel_reg,
                            rstat_reg};

endmodule

FILE: rtl/i2cbts_checker.sv
// Port-level checker for the transfer sequencer, bound to the top level.
module i2cbts_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [i2cbts_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // every request transfer yields a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("request transfer without result");

    // no transmit byte without tx_valid
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[6] |-> m_axis_tdata[14:7] == 8'd0)
        else $error("tx_byte set without tx_valid");

    // a stop is only issued with the bus released and never with a start
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[2] && !m_axis_tdata[3])
        else $error("stop without release or with start");

    // a start request result is never the unused code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("bad request status");

endmodule

bind i2c_buffered_transfer_sequencer_core i2cbts_checker u_i2cbts_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
